>>> rtl/core/gih_pkg.sv
// Shared types, codes and constants of the grid interpolation histogram.
`default_nettype none
package gih_pkg;
	localparam int X_POINTS_DEF = 64;
	localparam int Y_POINTS_DEF = 64;
	localparam int NUM_BINS_DEF = 30;

	localparam logic [6:0] X_USED_RST    = 7'd64;
	localparam logic [6:0] Y_USED_RST    = 7'd64;
	localparam logic [4:0] BINS_USED_RST = 5'd30;

	localparam logic [1:0] CFG_X_USED    = 2'd0;
	localparam logic [1:0] CFG_Y_USED    = 2'd1;
	localparam logic [1:0] CFG_BINS_USED = 2'd2;

	localparam logic [2:0] ACT_WR_X  = 3'd0;
	localparam logic [2:0] ACT_WR_Y  = 3'd1;
	localparam logic [2:0] ACT_WR_Z  = 3'd2;
	localparam logic [2:0] ACT_WR_B  = 3'd3;
	localparam logic [2:0] ACT_PART  = 3'd4;
	localparam logic [2:0] ACT_READ  = 3'd5;

	localparam logic [2:0] OP_NONE = 3'd0;
	localparam logic [2:0] OP_WR_X = 3'd1;
	localparam logic [2:0] OP_WR_Y = 3'd2;
	localparam logic [2:0] OP_WR_Z = 3'd3;
	localparam logic [2:0] OP_WR_B = 3'd4;
	localparam logic [2:0] OP_PART = 3'd5;
	localparam logic [2:0] OP_READ = 3'd6;

	localparam int IQ_DEPTH  = 4;
	localparam int RQ_DEPTH  = 2;
	localparam int FRAC_BITS = 16;

	typedef struct packed {
		logic [2:0]         action;
		logic [11:0]        index;
		logic signed [31:0] value;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
	} item_t;

	typedef struct packed {
		logic [4:0]  bin_number;
		logic [15:0] bin_count;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [2:0]         op;
		logic [11:0]        index;
		logic signed [31:0] value;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
	} req_t;

	typedef struct packed {
		logic [6:0] x_used;
		logic [6:0] y_used;
		logic [4:0] bins_used;
	} cfg_t;
endpackage
`default_nettype wire

>>> rtl/core/gih_front.sv
// Front end: accepts items, classifies them and queues the requests for the engine.
`default_nettype none
module gih_front #(
	parameter int X_POINTS = gih_pkg::X_POINTS_DEF,
	parameter int Y_POINTS = gih_pkg::Y_POINTS_DEF,
	parameter int NUM_BINS = gih_pkg::NUM_BINS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire gih_pkg::item_t item,
	output logic               req_valid,
	output gih_pkg::req_t      req,
	input  wire logic          req_pop
);
	localparam int PW     = $clog2(gih_pkg::IQ_DEPTH);
	localparam int ZDEPTH = X_POINTS * Y_POINTS;

	gih_pkg::req_t cls;
	gih_pkg::req_t q_mem [gih_pkg::IQ_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   cnt_q;
	logic          wr_en;

	// Writes outside their table and unused codes are dropped here.
	always_comb begin
		cls.op    = gih_pkg::OP_NONE;
		cls.index = item.index;
		cls.value = item.value;
		cls.pos_x = item.pos_x;
		cls.pos_y = item.pos_y;
		case (item.action)
			gih_pkg::ACT_WR_X: if (32'(item.index) < X_POINTS) cls.op = gih_pkg::OP_WR_X;
			gih_pkg::ACT_WR_Y: if (32'(item.index) < Y_POINTS) cls.op = gih_pkg::OP_WR_Y;
			gih_pkg::ACT_WR_Z: if (32'(item.index) < ZDEPTH) cls.op = gih_pkg::OP_WR_Z;
			gih_pkg::ACT_WR_B: if (32'(item.index) < NUM_BINS + 1) cls.op = gih_pkg::OP_WR_B;
			gih_pkg::ACT_PART: cls.op = gih_pkg::OP_PART;
			gih_pkg::ACT_READ: cls.op = gih_pkg::OP_READ;
			default: cls.op = gih_pkg::OP_NONE;
		endcase
	end

	assign full      = (cnt_q == (PW+1)'(gih_pkg::IQ_DEPTH));
	assign req_valid = (cnt_q != '0);
	assign req       = q_mem[rd_ptr_q];
	assign wr_en     = push && !full && (cls.op != gih_pkg::OP_NONE);

	always_ff @(posedge clk) begin
		if (wr_en) q_mem[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= PW'(wr_ptr_q + 1'b1);
			if (req_pop) rd_ptr_q <= PW'(rd_ptr_q + 1'b1);
			if (wr_en && !req_pop) cnt_q <= cnt_q + 1'b1;
			else if (!wr_en && req_pop) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/gih_res_queue.sv
// Result queue between the engine and the result port.
`default_nettype none
module gih_res_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             res_push,
	input  wire gih_pkg::result_t res_item,
	output logic                  res_full,
	output logic                  empty,
	input  wire logic             pop,
	output gih_pkg::result_t      result
);
	localparam int PW = $clog2(gih_pkg::RQ_DEPTH);

	gih_pkg::result_t q_mem [gih_pkg::RQ_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   cnt_q;
	logic          wr_en, rd_en;

	assign res_full = (cnt_q == (PW+1)'(gih_pkg::RQ_DEPTH));
	assign empty    = (cnt_q == '0);
	assign result   = q_mem[rd_ptr_q];
	assign wr_en    = res_push && !res_full;
	assign rd_en    = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr_en) q_mem[wr_ptr_q] <= res_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= PW'(wr_ptr_q + 1'b1);
			if (rd_en) rd_ptr_q <= PW'(rd_ptr_q + 1'b1);
			if (wr_en && !rd_en) cnt_q <= cnt_q + 1'b1;
			else if (!wr_en && rd_en) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/gih_engine.sv
// Back end: table memories, grid search, fraction divider, interpolation and bin counters.
`default_nettype none
module gih_engine #(
	parameter int X_POINTS = gih_pkg::X_POINTS_DEF,
	parameter int Y_POINTS = gih_pkg::Y_POINTS_DEF,
	parameter int NUM_BINS = gih_pkg::NUM_BINS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire gih_pkg::cfg_t    cfg,
	input  wire logic             req_valid,
	input  wire gih_pkg::req_t    req,
	output logic                  req_pop,
	output logic                  res_push,
	output gih_pkg::result_t      res_item,
	input  wire logic             res_full
);
	localparam int XAW    = $clog2(X_POINTS);
	localparam int YAW    = $clog2(Y_POINTS);
	localparam int XCW    = $clog2(X_POINTS + 1);
	localparam int YCW    = $clog2(Y_POINTS + 1);
	localparam int ZDEPTH = X_POINTS * Y_POINTS;
	localparam int ZAW    = $clog2(ZDEPTH);
	localparam int NBND   = NUM_BINS + 1;
	localparam int BAW    = $clog2(NBND);
	localparam int KW     = $clog2(NBND + 1);
	localparam int NBW    = $clog2(NUM_BINS + 1);
	localparam int BIW    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int XYMAX  = (X_POINTS > Y_POINTS) ? X_POINTS : Y_POINTS;
	localparam int SMAX   = (XYMAX > NBND) ? XYMAX : NBND;
	localparam int SW     = $clog2(SMAX + 1);
	localparam int FB     = gih_pkg::FRAC_BITS;
	localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SCAN  = 4'd1;
	localparam logic [3:0] ST_CHECK = 4'd2;
	localparam logic [3:0] ST_LOAD0 = 4'd3;
	localparam logic [3:0] ST_LOAD1 = 4'd4;
	localparam logic [3:0] ST_LOAD2 = 4'd5;
	localparam logic [3:0] ST_FRAC  = 4'd6;
	localparam logic [3:0] ST_DCHK  = 4'd7;
	localparam logic [3:0] ST_DIV   = 4'd8;
	localparam logic [3:0] ST_ZRD   = 4'd9;
	localparam logic [3:0] ST_ZMUL  = 4'd10;
	localparam logic [3:0] ST_ZACC  = 4'd11;
	localparam logic [3:0] ST_VAL   = 4'd12;
	localparam logic [3:0] ST_BSCAN = 4'd13;
	localparam logic [3:0] ST_BUPD  = 4'd14;
	localparam logic [3:0] ST_READ  = 4'd15;

	logic [3:0]    state_q;
	logic [SW-1:0] i_q, tag_s1;
	logic          scan_v_s1;
	logic          sel_q;
	logic [1:0]    c_q;
	logic [3:0]    dcnt_q;
	logic [BIW-1:0] b_q;

	logic [XCW-1:0] nx, cx_q;
	logic [YCW-1:0] ny, cy_q;
	logic [NBW-1:0] nb;
	logic [KW-1:0]  k_q;
	logic [XAW-1:0] ix_q, x_ra;
	logic [YAW-1:0] iy_q, y_ra;
	logic [ZAW-1:0] z_ra;
	logic [BAW-1:0] b_ra;

	logic signed [31:0] x_mem [X_POINTS];
	logic signed [31:0] y_mem [Y_POINTS];
	logic signed [31:0] z_mem [ZDEPTH];
	logic signed [31:0] b_mem [NBND];
	logic signed [31:0] x_rd_q, y_rd_q, z_rd_q, b_rd_q;

	logic signed [31:0] px_q, py_q, ax_q, ay_q, bx_q, by_q, val_q;
	logic signed [32:0] num_q, den_q;
	logic [31:0]        rem_q, rem_next;
	logic [32:0]        rem2;
	logic [FB-1:0]      quo_q, quo_next;
	logic               quo_bit;
	logic [FB:0]        tx_q, ty_q, frac_val, wa, wb;
	logic               frac_done;
	logic [2*FB+1:0]    w_q;
	logic signed [66:0] p_q, acc_q;
	logic               round_up;
	logic [15:0]        bin_cnt_q [NUM_BINS];
	logic [BIW-1:0]     kidx;

	// Register values outside their range are clamped at the point of use.
	always_comb begin
		if (cfg.x_used < 7'd2) nx = XCW'(2);
		else if (32'(cfg.x_used) > X_POINTS) nx = XCW'(X_POINTS);
		else nx = XCW'(cfg.x_used);
		if (cfg.y_used < 7'd2) ny = YCW'(2);
		else if (32'(cfg.y_used) > Y_POINTS) ny = YCW'(Y_POINTS);
		else ny = YCW'(cfg.y_used);
		if (cfg.bins_used < 5'd1) nb = NBW'(1);
		else if (32'(cfg.bins_used) > NUM_BINS) nb = NBW'(NUM_BINS);
		else nb = NBW'(cfg.bins_used);
	end

	assign req_pop = (state_q == ST_IDLE) && req_valid;

	// Read addresses for the table memories.
	always_comb begin
		x_ra = XAW'(i_q);
		y_ra = YAW'(i_q);
		if (state_q == ST_LOAD0) begin
			x_ra = ix_q;
			y_ra = iy_q;
		end else if (state_q == ST_LOAD1) begin
			x_ra = XAW'(ix_q + 1'b1);
			y_ra = YAW'(iy_q + 1'b1);
		end
		b_ra = BAW'(i_q);
		z_ra = ZAW'((32'(iy_q) + 32'(c_q[1])) * X_POINTS + 32'(ix_q) + 32'(c_q[0]));
	end

	always_ff @(posedge clk) begin
		if (req_pop && req.op == gih_pkg::OP_WR_X) x_mem[XAW'(req.index)] <= req.value;
		x_rd_q <= x_mem[x_ra];
	end

	always_ff @(posedge clk) begin
		if (req_pop && req.op == gih_pkg::OP_WR_Y) y_mem[YAW'(req.index)] <= req.value;
		y_rd_q <= y_mem[y_ra];
	end

	always_ff @(posedge clk) begin
		if (req_pop && req.op == gih_pkg::OP_WR_Z) z_mem[ZAW'(req.index)] <= req.value;
		z_rd_q <= z_mem[z_ra];
	end

	always_ff @(posedge clk) begin
		if (req_pop && req.op == gih_pkg::OP_WR_B) b_mem[BAW'(req.index)] <= req.value;
		b_rd_q <= b_mem[b_ra];
	end

	// One quotient bit per cycle; the numerator is always below the denominator here.
	always_comb begin
		rem2     = {rem_q, 1'b0};
		quo_bit  = (rem2 >= 33'(den_q));
		rem_next = quo_bit ? 32'(rem2 - 33'(den_q)) : rem2[31:0];
		quo_next = {quo_q[FB-2:0], quo_bit};
		frac_done = 1'b0;
		frac_val  = '0;
		if (state_q == ST_DCHK) begin
			if (den_q <= 0 || num_q <= 0) begin
				frac_done = 1'b1;
			end else if (num_q >= den_q) begin
				frac_done = 1'b1;
				frac_val  = ONE;
			end
		end else if (state_q == ST_DIV && dcnt_q == 4'(FB - 1)) begin
			frac_done = 1'b1;
			frac_val  = {1'b0, quo_next};
		end
	end

	assign wa       = c_q[0] ? tx_q : (FB+1)'(ONE - tx_q);
	assign wb       = c_q[1] ? ty_q : (FB+1)'(ONE - ty_q);
	assign round_up = acc_q[66] && (acc_q[31:0] != 32'd0);
	assign kidx     = BIW'(k_q - 1'b1);

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			i_q       <= '0;
			tag_s1    <= '0;
			scan_v_s1 <= 1'b0;
			sel_q     <= 1'b0;
			c_q       <= '0;
			dcnt_q    <= '0;
			b_q       <= '0;
		end else begin
			scan_v_s1 <= (state_q == ST_SCAN && i_q < SW'(XYMAX)) ||
				(state_q == ST_BSCAN && i_q < SW'(NBND));
			tag_s1 <= i_q;
			case (state_q)
				ST_IDLE: begin
					if (req_pop && req.op == gih_pkg::OP_PART) begin
						i_q     <= '0;
						state_q <= ST_SCAN;
					end else if (req_pop && req.op == gih_pkg::OP_READ) begin
						b_q     <= BIW'(NUM_BINS - 1);
						state_q <= ST_READ;
					end
				end
				ST_SCAN: begin
					if (i_q < SW'(XYMAX)) i_q <= SW'(i_q + 1'b1);
					else if (!scan_v_s1) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (cx_q != '0 && cx_q < nx && cy_q != '0 && cy_q < ny) state_q <= ST_LOAD0;
					else state_q <= ST_IDLE;
				end
				ST_LOAD0: state_q <= ST_LOAD1;
				ST_LOAD1: state_q <= ST_LOAD2;
				ST_LOAD2: begin
					sel_q   <= 1'b0;
					state_q <= ST_FRAC;
				end
				ST_FRAC: state_q <= ST_DCHK;
				ST_DCHK, ST_DIV: begin
					if (state_q == ST_DCHK) dcnt_q <= '0;
					else dcnt_q <= dcnt_q + 1'b1;
					if (frac_done) begin
						if (!sel_q) begin
							sel_q   <= 1'b1;
							state_q <= ST_FRAC;
						end else begin
							c_q     <= '0;
							state_q <= ST_ZRD;
						end
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_ZRD: state_q <= ST_ZMUL;
				ST_ZMUL: state_q <= ST_ZACC;
				ST_ZACC: begin
					c_q <= c_q + 1'b1;
					state_q <= (c_q == 2'd3) ? ST_VAL : ST_ZRD;
				end
				ST_VAL: begin
					i_q     <= '0;
					state_q <= ST_BSCAN;
				end
				ST_BSCAN: begin
					if (i_q < SW'(NBND)) i_q <= SW'(i_q + 1'b1);
					else if (!scan_v_s1) state_q <= ST_BUPD;
				end
				ST_BUPD: state_q <= ST_IDLE;
				ST_READ: begin
					if (!res_full) begin
						if (b_q == '0) state_q <= ST_IDLE;
						else b_q <= b_q - 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				px_q <= req.pos_x;
				py_q <= req.pos_y;
				cx_q <= '0;
				cy_q <= '0;
			end
			ST_SCAN: begin
				if (scan_v_s1 && 32'(tag_s1) < 32'(nx) && x_rd_q <= px_q) cx_q <= cx_q + 1'b1;
				if (scan_v_s1 && 32'(tag_s1) < 32'(ny) && y_rd_q <= py_q) cy_q <= cy_q + 1'b1;
			end
			ST_CHECK: begin
				ix_q <= XAW'(cx_q - 1'b1);
				iy_q <= YAW'(cy_q - 1'b1);
			end
			ST_LOAD1: begin
				ax_q <= x_rd_q;
				ay_q <= y_rd_q;
			end
			ST_LOAD2: begin
				bx_q <= x_rd_q;
				by_q <= y_rd_q;
			end
			ST_FRAC: begin
				if (!sel_q) begin
					num_q <= 33'(px_q) - 33'(ax_q);
					den_q <= 33'(bx_q) - 33'(ax_q);
				end else begin
					num_q <= 33'(py_q) - 33'(ay_q);
					den_q <= 33'(by_q) - 33'(ay_q);
				end
			end
			ST_DCHK, ST_DIV: begin
				if (state_q == ST_DCHK) begin
					rem_q <= num_q[31:0];
					quo_q <= '0;
				end else begin
					rem_q <= rem_next;
					quo_q <= quo_next;
				end
				if (frac_done) begin
					if (!sel_q) tx_q <= frac_val;
					else ty_q <= frac_val;
				end
				acc_q <= '0;
			end
			ST_ZRD: w_q <= wa * wb;
			ST_ZMUL: p_q <= $signed({1'b0, w_q}) * z_rd_q;
			ST_ZACC: acc_q <= acc_q + p_q;
			ST_VAL: begin
				val_q <= acc_q[63:32] + {31'd0, round_up};
				k_q   <= '0;
			end
			ST_BSCAN: begin
				if (scan_v_s1 && 32'(tag_s1) < 32'(nb) + 1 && b_rd_q <= val_q) k_q <= k_q + 1'b1;
			end
			default: ;
		endcase
	end

	// Bin counters: saturating increment and clear on readout.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < NUM_BINS; n++) bin_cnt_q[n] <= '0;
		end else if (state_q == ST_BUPD) begin
			if (k_q != '0 && 32'(k_q) <= 32'(nb) && bin_cnt_q[kidx] != 16'hFFFF)
				bin_cnt_q[kidx] <= bin_cnt_q[kidx] + 1'b1;
		end else if (res_push) begin
			bin_cnt_q[b_q] <= '0;
		end
	end

	assign res_push            = (state_q == ST_READ) && !res_full;
	assign res_item.bin_number = 5'(b_q);
	assign res_item.bin_count  = bin_cnt_q[b_q];
	assign res_item.last       = (b_q == '0);
endmodule
`default_nettype wire

>>> rtl/core/grid_interp_histogram.sv
// Top level of the grid interpolation histogram: configuration registers and the two halves.
//
// Items enter through push/full: table writes for the x grid, y grid, z grid and bin
// boundaries, particle positions, and readout requests. A front queue of four entries
// takes items while the engine is busy; writes outside their table are dropped there.
// A table write is done as the engine takes it from the queue. A particle's processing
// time is set by two linear scans over the grid and boundary memories, one memory read
// per entry, and two fraction divisions.
// A readout request gives NUM_BINS results, highest bin first, one per cycle while
// the result queue has room, with last set on bin 0, and clears each bin as it is
// sent. Results wait in a two-entry queue read through empty/pop; when the receiver
// stalls, the engine holds and the front keeps accepting until its queue fills.
// Configuration writes (cfg_valid/cfg_ready, always ready) set the used grid points
// and bins; they are meant to be made while the block is idle.
// Reset clears all queues and bin counts and loads 64, 64 and 30 into the registers;
// the table memories hold nothing defined until written.
`default_nettype none
module grid_interp_histogram #(
	parameter int X_POINTS = gih_pkg::X_POINTS_DEF,
	parameter int Y_POINTS = gih_pkg::Y_POINTS_DEF,
	parameter int NUM_BINS = gih_pkg::NUM_BINS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire gih_pkg::item_t   item,
	output logic                  empty,
	input  wire logic             pop,
	output gih_pkg::result_t      result,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [31:0]      cfg_data
);
	gih_pkg::cfg_t    cfg_q;
	logic             req_valid, req_pop;
	gih_pkg::req_t    req;
	logic             res_push, res_full;
	gih_pkg::result_t res_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_used    <= gih_pkg::X_USED_RST;
			cfg_q.y_used    <= gih_pkg::Y_USED_RST;
			cfg_q.bins_used <= gih_pkg::BINS_USED_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				gih_pkg::CFG_X_USED:    cfg_q.x_used    <= cfg_data[6:0];
				gih_pkg::CFG_Y_USED:    cfg_q.y_used    <= cfg_data[6:0];
				gih_pkg::CFG_BINS_USED: cfg_q.bins_used <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	gih_front #(.X_POINTS(X_POINTS), .Y_POINTS(Y_POINTS), .NUM_BINS(NUM_BINS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.req_valid (req_valid),
		.req       (req),
		.req_pop   (req_pop)
	);

	gih_engine #(.X_POINTS(X_POINTS), .Y_POINTS(Y_POINTS), .NUM_BINS(NUM_BINS)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req_valid (req_valid),
		.req       (req),
		.req_pop   (req_pop),
		.res_push  (res_push),
		.res_item  (res_item),
		.res_full  (res_full)
	);

	gih_res_queue u_res_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_item (res_item),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);
endmodule
`default_nettype wire

>>> rtl/core/gih_checker.sv
// Port checker for the grid interpolation histogram, bound to the top level.
`default_nettype none
module gih_checker #(
	parameter int NUM_BINS = gih_pkg::NUM_BINS_DEF
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             empty,
	input wire logic             pop,
	input wire gih_pkg::result_t result
);
	// The final result of a readout run always reports bin 0.
	a_last_bin0: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.last |-> result.bin_number == 5'd0)
		else $error("last result is not bin 0");

	// A reported bin is always one that exists.
	a_bin_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> 32'(result.bin_number) < NUM_BINS)
		else $error("bin number out of range");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("waiting result withdrawn");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(result))
		else $error("waiting result changed");
endmodule

bind grid_interp_histogram gih_checker #(.NUM_BINS(NUM_BINS)) u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
`default_nettype wire
